@@ src/bint_pkg.sv @@
// Package for the binary image thinning block: state codes, pixel codes,
// opcodes, register reset values and the neighbour offset table.
// No dependencies.
package bint_pkg;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CLS,
      ST_SUB,
      ST_MARK,
      ST_DEL
   } state_type;

   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_RUN   = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;
   localparam logic [1:0] OP_NONE  = 2'd3;

   localparam logic [1:0] CODE_BG       = 2'd0;
   localparam logic [1:0] CODE_FG       = 2'd1;
   localparam logic [1:0] CODE_INTERIOR = 2'd2;
   localparam logic [1:0] CODE_BORDER   = 2'd3;

   localparam logic [1:0] REG_WIDTH  = 2'd0;
   localparam logic [1:0] REG_HEIGHT = 2'd1;
   localparam logic [1:0] REG_MAXSUB = 2'd2;

   localparam logic [6:0]  WIDTH_RESET  = 7'd64;
   localparam logic [6:0]  HEIGHT_RESET = 7'd64;
   localparam logic [13:0] MAXSUB_RESET = 14'd10000;

   localparam logic [3:0] LAST_STEP = 4'd9;

   typedef struct packed {
      logic up;
      logic down;
      logic left;
      logic right;
   } nbr_off_type;

   // Step 0 is the centre, steps 1 to 8 walk p2 to p9.
   function automatic nbr_off_type nbr_off(input logic [3:0] idx);
      nbr_off_type o;
      o = '0;
      case (idx)
         4'd1: o.up = 1'b1;
         4'd2: begin o.up = 1'b1; o.right = 1'b1; end
         4'd3: o.right = 1'b1;
         4'd4: begin o.down = 1'b1; o.right = 1'b1; end
         4'd5: o.down = 1'b1;
         4'd6: begin o.down = 1'b1; o.left = 1'b1; end
         4'd7: o.left = 1'b1;
         4'd8: begin o.up = 1'b1; o.left = 1'b1; end
         default: o = '0;
      endcase
      return o;
   endfunction

endpackage

@@ src/binary_image_thinning.sv @@
// Top level of the binary image thinning block: pixel store, mark store,
// scan sequencer and register port.
// Depends on bint_pkg.
//
// After reset the block sweeps the pixel store to background, one entry per
// cycle, through all MIN(MAX_WIDTH,127) * MIN(MAX_HEIGHT,127) entries, with busy high.
// A write or read word is served in the idle state and leaves busy low; a
// read result appears with rsp_valid in the following cycle and must be taken
// then. A run word holds busy high while the image is scanned through the
// single read port of the pixel store, one store read per step, with skipped
// pixels left after their centre read: one classification scan and then a
// mark scan and a delete scan for each subiteration.
module binary_image_thinning #(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic [11:0] req_pixel_address,
   input  logic        req_pixel_value,
   output logic        rsp_valid,
   output logic        rsp_skeleton_bit,
   output logic [13:0] rsp_subiterations_used,
   output logic        rsp_hit_limit,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int LIM_W = (MAX_WIDTH < 127) ? MAX_WIDTH : 127;
   localparam int LIM_H = (MAX_HEIGHT < 127) ? MAX_HEIGHT : 127;
   localparam int DEPTH = LIM_W * LIM_H;
   localparam int DW = $clog2(DEPTH);
   localparam int XW = (DW > 12) ? DW : 12;
   localparam int CW = $clog2(LIM_W);
   localparam int RW = $clog2(LIM_H);

   logic [1:0] store_mem [DEPTH];
   logic       mark_mem [DEPTH];

   bint_pkg::state_type state_ff, state_in;
   logic [3:0]  step_ff, step_in;
   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic [DW-1:0] k_ff, k_in;
   logic        pass_ff, pass_in;
   logic        changed_ff, changed_in;
   logic        any_ff, any_in;
   logic        edge_ff, edge_in;
   logic [13:0] count_ff, count_in;
   logic        limit_ff, limit_in;
   logic [7:1]  nb_ff, nb_in;
   logic        inside_ff, inside_in;
   logic [DW-1:0] rdaddr_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rd_ok_ff, rd_ok_in;
   logic [6:0]  width_ff, height_ff;
   logic [13:0] maxsub_ff;
   logic [1:0]  rd_ff;
   logic        mark_rd_ff;

   logic [DW-1:0] rd_addr, wr_addr;
   logic          wr_en, mk_wr_en, mk_wr_data;
   logic [1:0]    wr_data;

   logic [6:0]  eff_w, eff_h;
   logic [13:0] area;
   logic        in_area, accept, last_col, last_row, nb_val, cond, adv, done;
   logic [XW-1:0] addr_x;
   logic [DW-1:0] wx, nb_addr;
   logic [3:0]  rx_idx;
   logic        p2, p3, p4, p5, p6, p7, p8, p9;
   logic [2:0]  cn, n1, n2, nmin;
   logic        mtest;
   bint_pkg::nbr_off_type off;

   always_comb begin
      if (width_ff < 7'd3) eff_w = 7'd3;
      else if (width_ff > 7'(LIM_W)) eff_w = 7'(LIM_W);
      else eff_w = width_ff;
      if (height_ff < 7'd3) eff_h = 7'd3;
      else if (height_ff > 7'(LIM_H)) eff_h = 7'(LIM_H);
      else eff_h = height_ff;
   end

   assign area    = 14'(eff_w) * 14'(eff_h);
   assign in_area = {2'b00, req_pixel_address} < area;
   assign addr_x  = XW'(req_pixel_address);
   assign busy    = (state_ff != bint_pkg::ST_IDLE);
   assign accept  = start && !busy;

   assign last_col = (7'(col_ff) == eff_w - 7'd1);
   assign last_row = (7'(row_ff) == eff_h - 7'd1);

   assign off = bint_pkg::nbr_off(step_ff);
   assign wx  = DW'(eff_w);
   assign nb_addr = k_ff + (off.up ? (~wx + DW'(1)) : (off.down ? wx : '0))
                    + (off.left ? {DW{1'b1}} : (off.right ? DW'(1) : '0));
   assign inside_in = !(off.up && row_ff == '0) && !(off.down && last_row)
                      && !(off.left && col_ff == '0) && !(off.right && last_col);

   assign rx_idx = step_ff - 4'd1;
   assign nb_val = inside_ff && (rd_ff != bint_pkg::CODE_BG);

   assign p2 = nb_ff[1];
   assign p3 = nb_ff[2];
   assign p4 = nb_ff[3];
   assign p5 = nb_ff[4];
   assign p6 = nb_ff[5];
   assign p7 = nb_ff[6];
   assign p8 = nb_ff[7];
   assign p9 = nb_val;

   always_comb begin
      cn = 3'({2'b00, !p2 && (p3 || p4)}) + 3'({2'b00, !p4 && (p5 || p6)})
           + 3'({2'b00, !p6 && (p7 || p8)}) + 3'({2'b00, !p8 && (p9 || p2)});
      n1 = 3'({2'b00, p9 || p2}) + 3'({2'b00, p3 || p4})
           + 3'({2'b00, p5 || p6}) + 3'({2'b00, p7 || p8});
      n2 = 3'({2'b00, p2 || p3}) + 3'({2'b00, p4 || p5})
           + 3'({2'b00, p6 || p7}) + 3'({2'b00, p8 || p9});
      nmin = (n1 < n2) ? n1 : n2;
      mtest = pass_ff ? ((p2 || p3 || !p5) && p4) : ((p6 || p7 || !p9) && p8);
      cond = (cn == 3'd1) && (nmin >= 3'd2) && (nmin <= 3'd3) && !mtest;
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      k_in         = k_ff;
      pass_in      = pass_ff;
      changed_in   = changed_ff;
      any_in       = any_ff;
      edge_in      = edge_ff;
      count_in     = count_ff;
      limit_in     = limit_ff;
      nb_in        = nb_ff;
      rsp_valid_in = 1'b0;
      rd_ok_in     = rd_ok_ff;
      rd_addr      = nb_addr;
      wr_en        = 1'b0;
      wr_addr      = k_ff;
      wr_data      = bint_pkg::CODE_BG;
      mk_wr_en     = 1'b0;
      mk_wr_data   = 1'b0;
      adv          = 1'b0;
      done         = 1'b0;

      case (state_ff)
         bint_pkg::ST_CLEAR: begin
            wr_en = 1'b1;
            k_in  = k_ff + DW'(1);
            if (k_ff == DW'(DEPTH - 1)) begin
               k_in     = '0;
               state_in = bint_pkg::ST_IDLE;
            end
         end
         bint_pkg::ST_IDLE: begin
            rd_addr = addr_x[DW-1:0];
            wr_addr = addr_x[DW-1:0];
            wr_data = req_pixel_value ? bint_pkg::CODE_FG : bint_pkg::CODE_BG;
            if (accept) begin
               case (req_opcode)
                  bint_pkg::OP_WRITE: wr_en = in_area;
                  bint_pkg::OP_RUN: begin
                     state_in = bint_pkg::ST_CLS;
                     step_in  = '0;
                     row_in   = '0;
                     col_in   = '0;
                     k_in     = '0;
                  end
                  bint_pkg::OP_READ: begin
                     rsp_valid_in = 1'b1;
                     rd_ok_in     = in_area;
                  end
                  default: ;
               endcase
            end
         end
         bint_pkg::ST_CLS: begin
            step_in = step_ff + 4'd1;
            if (step_ff == 4'd1) begin
               edge_in = 1'b0;
               if (rd_ff == bint_pkg::CODE_BG) adv = 1'b1;
            end else if (step_ff >= 4'd2) begin
               if (rx_idx[0] && inside_ff && rd_ff == bint_pkg::CODE_BG) edge_in = 1'b1;
               if (step_ff == bint_pkg::LAST_STEP) begin
                  wr_en   = 1'b1;
                  wr_data = (edge_ff || (rx_idx[0] && inside_ff && rd_ff == bint_pkg::CODE_BG))
                            ? bint_pkg::CODE_BORDER : bint_pkg::CODE_INTERIOR;
                  adv = 1'b1;
               end
            end
         end
         bint_pkg::ST_SUB: begin
            step_in = '0;
            if (count_ff >= maxsub_ff) begin
               limit_in = 1'b1;
               state_in = bint_pkg::ST_IDLE;
            end else begin
               any_in   = 1'b0;
               state_in = bint_pkg::ST_MARK;
            end
         end
         bint_pkg::ST_MARK: begin
            step_in = step_ff + 4'd1;
            if (step_ff == 4'd1) begin
               if (rd_ff != bint_pkg::CODE_BORDER) begin
                  mk_wr_en = 1'b1;
                  adv      = 1'b1;
               end
            end else if (step_ff >= 4'd2) begin
               if (step_ff == bint_pkg::LAST_STEP) begin
                  mk_wr_en   = 1'b1;
                  mk_wr_data = cond;
                  any_in     = any_ff || cond;
                  adv        = 1'b1;
               end else begin
                  nb_in[rx_idx[2:0]] = nb_val;
               end
            end
         end
         bint_pkg::ST_DEL: begin
            step_in = step_ff + 4'd1;
            if (step_ff == 4'd1) begin
               if (!mark_rd_ff) adv = 1'b1;
               else wr_en = 1'b1;
            end else if (step_ff >= 4'd2) begin
               wr_addr = rdaddr_ff;
               wr_data = bint_pkg::CODE_BORDER;
               wr_en   = rx_idx[0] && inside_ff && rd_ff == bint_pkg::CODE_INTERIOR;
               if (step_ff == bint_pkg::LAST_STEP) adv = 1'b1;
            end
         end
         default: state_in = bint_pkg::ST_IDLE;
      endcase

      if (adv) begin
         step_in = '0;
         k_in    = k_ff + DW'(1);
         col_in  = col_ff + CW'(1);
         if (last_col) begin
            col_in = '0;
            row_in = row_ff + RW'(1);
            if (last_row) begin
               done   = 1'b1;
               row_in = '0;
               k_in   = '0;
            end
         end
      end

      if (done) begin
         case (state_ff)
            bint_pkg::ST_CLS: begin
               count_in   = '0;
               limit_in   = 1'b0;
               changed_in = 1'b0;
               pass_in    = 1'b0;
               state_in   = bint_pkg::ST_SUB;
            end
            bint_pkg::ST_MARK: state_in = bint_pkg::ST_DEL;
            bint_pkg::ST_DEL: begin
               count_in = count_ff + 14'd1;
               if (pass_ff) begin
                  pass_in    = 1'b0;
                  changed_in = 1'b0;
                  state_in   = (changed_ff || any_ff) ? bint_pkg::ST_SUB
                                                      : bint_pkg::ST_IDLE;
               end else begin
                  pass_in    = 1'b1;
                  changed_in = any_ff;
                  state_in   = bint_pkg::ST_SUB;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bint_pkg::ST_CLEAR;
         step_ff      <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         k_ff         <= '0;
         pass_ff      <= 1'b0;
         changed_ff   <= 1'b0;
         any_ff       <= 1'b0;
         count_ff     <= '0;
         limit_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rd_ok_ff     <= 1'b0;
         width_ff     <= bint_pkg::WIDTH_RESET;
         height_ff    <= bint_pkg::HEIGHT_RESET;
         maxsub_ff    <= bint_pkg::MAXSUB_RESET;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         k_ff         <= k_in;
         pass_ff      <= pass_in;
         changed_ff   <= changed_in;
         any_ff       <= any_in;
         count_ff     <= count_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_ok_ff     <= rd_ok_in;
         if (psel && penable && pwrite) begin
            case (paddr[3:2])
               bint_pkg::REG_WIDTH:  width_ff  <= pwdata[6:0];
               bint_pkg::REG_HEIGHT: height_ff <= pwdata[6:0];
               bint_pkg::REG_MAXSUB: maxsub_ff <= pwdata[13:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      edge_ff   <= edge_in;
      nb_ff     <= nb_in;
      inside_ff <= inside_in;
      rdaddr_ff <= nb_addr;
   end

   always_ff @(posedge clock) begin
      if (wr_en) store_mem[wr_addr] <= wr_data;
      rd_ff <= store_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (mk_wr_en) mark_mem[k_ff] <= mk_wr_data;
      mark_rd_ff <= mark_mem[k_ff];
   end

   always_comb begin
      case (paddr[3:2])
         bint_pkg::REG_WIDTH:  prdata = {25'd0, width_ff};
         bint_pkg::REG_HEIGHT: prdata = {25'd0, height_ff};
         bint_pkg::REG_MAXSUB: prdata = {18'd0, maxsub_ff};
         default:              prdata = '0;
      endcase
   end

   assign pready                 = 1'b1;
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_skeleton_bit       = rd_ok_ff && (rd_ff != bint_pkg::CODE_BG);
   assign rsp_subiterations_used = count_ff;
   assign rsp_hit_limit          = limit_ff;

   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy && req_opcode == bint_pkg::OP_READ))
      else $error("Result word without an accepted read.");

   a_run_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_opcode == bint_pkg::OP_RUN) |=> busy)
      else $error("Run word did not start the sequencer.");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= bint_pkg::LAST_STEP)
      else $error("Pixel step counter out of range.");

endmodule
